/* rtl/greedy_threshold_match_count_macros.svh */
// Assertion macros shared by the checking code of the block.
`ifndef GREEDY_THRESHOLD_MATCH_COUNT_MACROS_SVH
`define GREEDY_THRESHOLD_MATCH_COUNT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GTMC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define GTMC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

/* rtl/gtmc_pkg.sv */
`timescale 1ns / 1ps

package gtmc_pkg;

   localparam int MAX_ITEMS_DEFAULT = 64;

   localparam logic [1:0] KIND_DEMAND = 2'd0;
   localparam logic [1:0] KIND_SUPPLY = 2'd1;
   localparam logic [1:0] KIND_FINISH = 2'd2;

   typedef struct packed {
      logic accept;
      logic ins_step;
      logic walk_step;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic is_finish;
      logic need_shift;
      logic ins_stop;
      logic walk_end;
      logic rsp_free;
   } status_type;

endpackage

/* rtl/gtmc_req_if.sv */
`timescale 1ns / 1ps

interface gtmc_req_if;
   logic              valid;
   logic              ready;
   logic [1:0]        req_type;
   logic signed [31:0] item_value;

   modport source (output valid, output req_type, output item_value, input ready);
   modport sink (input valid, input req_type, input item_value, output ready);
endinterface

/* rtl/gtmc_rsp_if.sv */
`timescale 1ns / 1ps

interface gtmc_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] matched_count;
   logic       overflowed;

   modport source (output valid, output matched_count, output overflowed, input ready);
   modport sink (input valid, input matched_count, input overflowed, output ready);
endinterface

/* rtl/greedy_threshold_match_count.sv */
`timescale 1ns / 1ps
// Greedy threshold matcher. Demand and supply values are loaded one per
// transfer and kept sorted in one RAM per list by insertion: a load into an
// empty or full list is finished when it is accepted, any other load then
// moves each stored entry larger than the new value up one place, one entry
// a cycle through the single read and write port of the RAM, and writes the
// new value into the hole. A finish transfer walks both sorted lists, one
// supply entry a cycle, and then waits in place only if the previous result
// has not been taken. The result sits in an output register, so loads are
// taken while it waits. Loads beyond MAX_ITEMS per list are dropped and
// reported with the next result, and each finish empties both lists. The
// RAMs need no clearing after reset.
`include "greedy_threshold_match_count_macros.svh"

module greedy_threshold_match_count #(
   parameter int MAX_ITEMS = gtmc_pkg::MAX_ITEMS_DEFAULT
) (
   input logic      clock,
   input logic      reset,
   gtmc_req_if.sink   req_ch,
   gtmc_rsp_if.source rsp_ch
);
   import gtmc_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       rsp_valid;
   logic [6:0] matched_count;
   logic       overflowed;
   logic       req_ready;

   gtmc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   gtmc_datapath #(
      .MAX_ITEMS (MAX_ITEMS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_type      (req_ch.req_type),
      .item_value    (req_ch.item_value),
      .cmd           (cmd),
      .status        (status),
      .rsp_ready     (rsp_ch.ready),
      .rsp_valid     (rsp_valid),
      .matched_count (matched_count),
      .overflowed    (overflowed)
   );

   assign req_ch.ready         = req_ready;
   assign rsp_ch.valid         = rsp_valid;
   assign rsp_ch.matched_count = matched_count;
   assign rsp_ch.overflowed    = overflowed;

   `GTMC_ASSERT_IMPLY(a_emit_slot_free, clock, reset, cmd.emit, !rsp_ch.valid || rsp_ch.ready)
   `GTMC_ASSERT_NEXT(a_emit_shows_result, clock, reset, cmd.emit, rsp_ch.valid)
   `GTMC_ASSERT_NEXT(a_finish_blocks_input, clock, reset, cmd.accept && status.is_finish, !req_ch.ready)
   `GTMC_ASSERT_IMPLY(a_one_activity, clock, reset, 1'b1, $onehot0({cmd.accept, cmd.ins_step, cmd.walk_step, cmd.emit}))

endmodule

/* rtl/gtmc_ram.sv */
`timescale 1ns / 1ps

module gtmc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/gtmc_ctrl.sv */
`timescale 1ns / 1ps

module gtmc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  gtmc_pkg::status_type status,
   output gtmc_pkg::cmd_type    cmd
);
   import gtmc_pkg::*;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SHIFT = 2'd1;
   localparam logic [1:0] S_WALK  = 2'd2;
   localparam logic [1:0] S_DONE  = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       accept;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      cmd.accept    = accept;
      cmd.ins_step  = (state_ff == S_SHIFT);
      cmd.walk_step = (state_ff == S_WALK) && !status.walk_end;
      cmd.emit      = (state_ff == S_DONE) && status.rsp_free;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept && status.is_finish) begin
               state_in = S_WALK;
            end else if (accept && status.need_shift) begin
               state_in = S_SHIFT;
            end
         end
         S_SHIFT: begin
            if (status.ins_stop) begin
               state_in = S_IDLE;
            end
         end
         S_WALK: begin
            if (status.walk_end) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (status.rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* rtl/gtmc_datapath.sv */
`timescale 1ns / 1ps

module gtmc_datapath #(
   parameter int MAX_ITEMS = gtmc_pkg::MAX_ITEMS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [1:0]           req_type,
   input  logic signed [31:0]   item_value,
   input  gtmc_pkg::cmd_type    cmd,
   output gtmc_pkg::status_type status,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output logic [6:0]           matched_count,
   output logic                 overflowed
);
   import gtmc_pkg::*;

   localparam int CW = $clog2(MAX_ITEMS + 1);
   localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;

   logic [CW-1:0]      dcount_ff, dcount_in;
   logic [CW-1:0]      scount_ff, scount_in;
   logic               ovf_ff, ovf_in;
   logic signed [31:0] key_ff, key_in;
   logic               sel_ff, sel_in;
   logic [CW-1:0]      pos_ff, pos_in;
   logic [CW-1:0]      si_ff, si_in;
   logic [CW-1:0]      di_ff, di_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [6:0]         rsp_count_ff, rsp_count_in;
   logic               rsp_ovf_ff, rsp_ovf_in;

   logic               is_load;
   logic               is_finish;
   logic               req_supply;
   logic [CW-1:0]      req_count;
   logic               req_full;
   logic [31:0]        d_rdata, s_rdata;
   logic signed [31:0] ins_rdata;
   logic               ins_stop;
   logic               walk_end;
   logic               advance;
   logic [CW-1:0]      si_next, di_next;
   logic [CW-1:0]      ins_idx, s_idx, d_idx;
   logic               walking;
   logic [AW-1:0]      s_raddr, d_raddr;
   logic               wr_en, wr_supply;
   logic [AW-1:0]      wr_addr;
   logic [31:0]        wr_data;
   logic [CW+6:0]      di_wide;

   assign is_load    = (req_type == KIND_DEMAND) || (req_type == KIND_SUPPLY);
   assign is_finish  = (req_type == KIND_FINISH);
   assign req_supply = (req_type == KIND_SUPPLY);
   assign req_count  = req_supply ? scount_ff : dcount_ff;
   assign req_full   = (req_count == CW'(MAX_ITEMS));

   assign ins_rdata = sel_ff ? $signed(s_rdata) : $signed(d_rdata);
   assign ins_stop  = (pos_ff == '0) || !(ins_rdata > key_ff);
   assign walk_end  = (si_ff >= scount_ff) || (di_ff >= dcount_ff);
   assign advance   = ($signed(s_rdata) >= $signed(d_rdata));
   assign si_next   = si_ff + CW'(1);
   assign di_next   = di_ff + CW'(advance);

   always_comb begin
      status.is_finish  = is_finish;
      status.need_shift = is_load && !req_full && (req_count != '0);
      status.ins_stop   = ins_stop;
      status.walk_end   = walk_end;
      status.rsp_free   = !rsp_valid_ff || rsp_ready;
   end

   // Read addresses: the insertion scan reads the entry just below the hole,
   // the walk reads the entries its two indices will point at next cycle.
   assign ins_idx = cmd.ins_step ? (pos_ff - CW'(2)) : (req_count - CW'(1));
   assign walking = cmd.walk_step || (cmd.accept && is_finish);
   assign s_idx   = cmd.walk_step ? si_next : '0;
   assign d_idx   = cmd.walk_step ? di_next : '0;
   assign s_raddr = walking ? s_idx[AW-1:0] : ins_idx[AW-1:0];
   assign d_raddr = walking ? d_idx[AW-1:0] : ins_idx[AW-1:0];

   always_comb begin
      wr_en     = 1'b0;
      wr_supply = sel_ff;
      wr_addr   = pos_ff[AW-1:0];
      wr_data   = ins_stop ? key_ff : ins_rdata;
      if (cmd.ins_step) begin
         wr_en = 1'b1;
      end else if (cmd.accept && is_load && !req_full && (req_count == '0)) begin
         wr_en     = 1'b1;
         wr_supply = req_supply;
         wr_addr   = '0;
         wr_data   = item_value;
      end
   end

   gtmc_ram #(
      .WIDTH (32),
      .DEPTH (MAX_ITEMS)
   ) u_demand_ram (
      .clock   (clock),
      .wr_en   (wr_en && !wr_supply),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (d_raddr),
      .rd_data (d_rdata)
   );

   gtmc_ram #(
      .WIDTH (32),
      .DEPTH (MAX_ITEMS)
   ) u_supply_ram (
      .clock   (clock),
      .wr_en   (wr_en && wr_supply),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (s_raddr),
      .rd_data (s_rdata)
   );

   assign di_wide = {7'd0, di_ff};

   always_comb begin
      dcount_in    = dcount_ff;
      scount_in    = scount_ff;
      ovf_in       = ovf_ff;
      key_in       = key_ff;
      sel_in       = sel_ff;
      pos_in       = pos_ff;
      si_in        = si_ff;
      di_in        = di_ff;
      rsp_count_in = rsp_count_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (cmd.accept && is_load) begin
         if (req_full) begin
            ovf_in = 1'b1;
         end else if (req_count == '0) begin
            if (req_supply) begin
               scount_in = CW'(1);
            end else begin
               dcount_in = CW'(1);
            end
         end else begin
            key_in = item_value;
            sel_in = req_supply;
            pos_in = req_count;
         end
      end

      if (cmd.accept && is_finish) begin
         si_in = '0;
         di_in = '0;
      end

      if (cmd.ins_step) begin
         if (ins_stop) begin
            if (sel_ff) begin
               scount_in = scount_ff + CW'(1);
            end else begin
               dcount_in = dcount_ff + CW'(1);
            end
         end else begin
            pos_in = pos_ff - CW'(1);
         end
      end

      if (cmd.walk_step) begin
         si_in = si_next;
         di_in = di_next;
      end

      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_count_in = di_wide[6:0];
         rsp_ovf_in   = ovf_ff;
         dcount_in    = '0;
         scount_in    = '0;
         ovf_in       = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dcount_ff    <= '0;
         scount_ff    <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         dcount_ff    <= dcount_in;
         scount_ff    <= scount_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff       <= key_in;
      sel_ff       <= sel_in;
      pos_ff       <= pos_in;
      si_ff        <= si_in;
      di_ff        <= di_in;
      rsp_count_ff <= rsp_count_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign matched_count = rsp_count_ff;
   assign overflowed    = rsp_ovf_ff;

endmodule
